/* rtl/pit_pkg.sv */
// Package with the shared types and codes of the pair interning table.
`timescale 1ns / 1ps
package pit_pkg;

    localparam int VAL_W = 32;
    localparam int IDX_W = 12;
    localparam int NODE_W = 4;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD_READ = 2'd2;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic                    req_type;
        logic                    node_ok;
        logic [NODE_W-1:0]       node;
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] right_value;
        logic [IDX_W-1:0]        entry_index;
        logic [VAL_W-1:0]        hash;
    } t_job;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0]        result_index;
        logic signed [VAL_W-1:0] out_left;
        logic signed [VAL_W-1:0] out_right;
        logic                    is_new;
        logic [1:0]              status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT_HEAD,
        S_DECIDE,
        S_WAIT_ENTRY,
        S_COMPARE,
        S_APPEND
    } t_state;

endpackage

/* rtl/pit_if.sv */
// Request and response channel interfaces of the pair interning table.
`timescale 1ns / 1ps
interface pit_req_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    req_type;
    logic [pit_pkg::NODE_W-1:0]              node;
    logic signed [pit_pkg::VAL_W-1:0]        left_value;
    logic signed [pit_pkg::VAL_W-1:0]        right_value;
    logic [pit_pkg::IDX_W-1:0]               entry_index;

    modport source (output valid, req_type, node, left_value, right_value, entry_index,
                    input ready);
    modport sink (input valid, req_type, node, left_value, right_value, entry_index,
                  output ready);
endinterface

interface pit_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic [pit_pkg::IDX_W-1:0]               result_index;
    logic signed [pit_pkg::VAL_W-1:0]        out_left;
    logic signed [pit_pkg::VAL_W-1:0]        out_right;
    logic                                    is_new;
    logic [1:0]                              status;

    modport source (output valid, result_index, out_left, out_right, is_new, status,
                    input ready);
    modport sink (input valid, result_index, out_left, out_right, is_new, status,
                  output ready);
endinterface

/* rtl/pit_front.sv */
// Front end: takes requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module pit_front #(
    parameter int NODES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [3:0]          i_node,
    input  logic signed [31:0]  i_left_value,
    input  logic signed [31:0]  i_right_value,
    input  logic [11:0]         i_entry_index,
    input  logic                i_clearing,
    output logic                o_job_valid,
    output pit_pkg::t_job       o_job,
    input  logic                i_job_pop
);

    pit_pkg::t_job r_q [pit_pkg::Q_DEPTH];
    logic [pit_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [pit_pkg::Q_AW:0]   r_cnt;
    pit_pkg::t_job w_job;
    logic w_push, w_pop;

    always_comb begin
        w_job.req_type    = i_req_type;
        w_job.node_ok     = (32'(i_node) < 32'(NODES));
        w_job.node        = i_node;
        w_job.left_value  = i_left_value;
        w_job.right_value = i_right_value;
        w_job.entry_index = i_entry_index;
        // The hash only picks a bucket; the back end keeps its low bits.
        w_job.hash        = i_left_value ^ {i_right_value[15:0], i_right_value[31:16]}
                            ^ {5'd0, i_right_value[31:5]};
    end

    assign o_ready     = (r_cnt != (pit_pkg::Q_AW+1)'(pit_pkg::Q_DEPTH)) && !i_clearing;
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];
    assign w_pop       = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_job;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (pit_pkg::Q_AW+1)'(w_push) - (pit_pkg::Q_AW+1)'(w_pop);
        end
    end

endmodule

/* rtl/pit_back.sv */
// Back end: bucket heads, pair store, chain walk, append and result register.
`timescale 1ns / 1ps
module pit_back #(
    parameter int NODES   = 16,
    parameter int ENTRIES = 4096,
    parameter int BUCKETS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  pit_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_clearing,
    output logic          o_rsp_valid,
    output pit_pkg::t_rsp o_rsp,
    input  logic          i_rsp_ready
);

    localparam int NB  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW  = $clog2(ENTRIES);
    localparam int BB  = $clog2(BUCKETS);
    localparam int FW  = $clog2(ENTRIES + 1);
    localparam int HAW = NB + BB;
    localparam int EAW = NB + LW;
    localparam int HD  = NODES * BUCKETS;
    localparam int ED  = NODES * ENTRIES;
    localparam int PW  = 2 * pit_pkg::VAL_W + LW + 1;

    logic [LW:0]  mem_head [HD];
    logic [PW-1:0] mem_pair [ED];

    pit_pkg::t_state r_state, n_state;
    pit_pkg::t_job   r_job, n_job;
    logic [NB-1:0]   r_nd, n_nd;
    logic [HAW-1:0]  r_haddr, n_haddr, r_clr, n_clr;
    logic [EAW-1:0]  r_eaddr, n_eaddr;
    logic [LW-1:0]   r_cur, n_cur;
    logic [LW:0]     r_hdata;
    logic [PW-1:0]   r_edata;
    logic [FW-1:0]   r_fill [NODES];
    pit_pkg::t_rsp   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            w_head_we, w_pair_we, w_fill_inc;
    logic [HAW-1:0]  w_head_addr;
    logic [LW:0]     w_head_data;
    logic [EAW-1:0]  w_pair_addr;
    logic [PW-1:0]   w_pair_data;
    logic [FW-1:0]   w_fill;
    logic            w_out_free;

    assign w_fill      = r_fill[r_nd];
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign o_clearing  = (r_state == pit_pkg::S_CLEAR);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_nd        = r_nd;
        n_haddr     = r_haddr;
        n_eaddr     = r_eaddr;
        n_cur       = r_cur;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_job_pop   = 1'b0;
        w_head_we   = 1'b0;
        w_head_addr = r_haddr;
        w_head_data = {1'b1, LW'(w_fill)};
        w_pair_we   = 1'b0;
        w_pair_addr = {r_nd, LW'(w_fill)};
        w_pair_data = {r_job.left_value, r_job.right_value, r_hdata};
        w_fill_inc  = 1'b0;
        case (r_state)
            pit_pkg::S_CLEAR: begin
                w_head_we   = 1'b1;
                w_head_addr = r_clr;
                w_head_data = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == HAW'(HD - 1)) begin
                    n_state = pit_pkg::S_IDLE;
                end
            end
            pit_pkg::S_IDLE: begin
                if (i_job_valid && w_out_free) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_nd      = NB'(i_job.node);
                    n_haddr   = {NB'(i_job.node), BB'(i_job.hash)};
                    n_eaddr   = {NB'(i_job.node), LW'(i_job.entry_index)};
                    n_state   = pit_pkg::S_WAIT_HEAD;
                end
            end
            pit_pkg::S_WAIT_HEAD: begin
                n_state = pit_pkg::S_DECIDE;
            end
            pit_pkg::S_DECIDE: begin
                n_out.is_new = 1'b0;
                if (r_job.req_type == pit_pkg::REQ_READ) begin
                    n_out.result_index = r_job.entry_index;
                    n_out_valid        = 1'b1;
                    n_state            = pit_pkg::S_IDLE;
                    if (!r_job.node_ok || (32'(r_job.entry_index) >= 32'(w_fill))) begin
                        n_out.out_left  = '0;
                        n_out.out_right = '0;
                        n_out.status    = pit_pkg::ST_BAD_READ;
                    end else begin
                        n_out.out_left  = r_edata[PW-1 -: pit_pkg::VAL_W];
                        n_out.out_right = r_edata[LW+pit_pkg::VAL_W : LW+1];
                        n_out.status    = pit_pkg::ST_OK;
                    end
                end else if (!r_job.node_ok) begin
                    n_out.result_index = '0;
                    n_out.out_left     = '0;
                    n_out.out_right    = '0;
                    n_out.status       = pit_pkg::ST_FULL;
                    n_out_valid        = 1'b1;
                    n_state            = pit_pkg::S_IDLE;
                end else if (r_hdata[LW]) begin
                    n_cur   = r_hdata[LW-1:0];
                    n_eaddr = {r_nd, r_hdata[LW-1:0]};
                    n_state = pit_pkg::S_WAIT_ENTRY;
                end else begin
                    n_state = pit_pkg::S_APPEND;
                end
            end
            pit_pkg::S_WAIT_ENTRY: begin
                n_state = pit_pkg::S_COMPARE;
            end
            pit_pkg::S_COMPARE: begin
                if (r_edata[PW-1 -: pit_pkg::VAL_W] == r_job.left_value
                    && r_edata[LW+pit_pkg::VAL_W : LW+1] == r_job.right_value) begin
                    n_out.result_index = pit_pkg::IDX_W'(r_cur);
                    n_out.out_left     = r_job.left_value;
                    n_out.out_right    = r_job.right_value;
                    n_out.is_new       = 1'b0;
                    n_out.status       = pit_pkg::ST_OK;
                    n_out_valid        = 1'b1;
                    n_state            = pit_pkg::S_IDLE;
                end else if (r_edata[LW]) begin
                    n_cur   = r_edata[LW-1:0];
                    n_eaddr = {r_nd, r_edata[LW-1:0]};
                    n_state = pit_pkg::S_WAIT_ENTRY;
                end else begin
                    n_state = pit_pkg::S_APPEND;
                end
            end
            pit_pkg::S_APPEND: begin
                n_out_valid = 1'b1;
                n_state     = pit_pkg::S_IDLE;
                if (w_fill == FW'(ENTRIES)) begin
                    n_out.result_index = '0;
                    n_out.out_left     = '0;
                    n_out.out_right    = '0;
                    n_out.is_new       = 1'b0;
                    n_out.status       = pit_pkg::ST_FULL;
                end else begin
                    // New entry links to the old head and becomes the head.
                    w_pair_we          = 1'b1;
                    w_head_we          = 1'b1;
                    w_fill_inc         = 1'b1;
                    n_out.result_index = pit_pkg::IDX_W'(w_fill);
                    n_out.out_left     = r_job.left_value;
                    n_out.out_right    = r_job.right_value;
                    n_out.is_new       = 1'b1;
                    n_out.status       = pit_pkg::ST_OK;
                end
            end
            default: begin
                n_state = pit_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            mem_head[w_head_addr] <= w_head_data;
        end
        r_hdata <= mem_head[r_haddr];
        if (w_pair_we) begin
            mem_pair[w_pair_addr] <= w_pair_data;
        end
        r_edata <= mem_pair[r_eaddr];
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_nd    <= n_nd;
        r_haddr <= n_haddr;
        r_eaddr <= n_eaddr;
        r_cur   <= n_cur;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= pit_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (w_fill_inc) begin
                r_fill[r_nd] <= w_fill + 1'b1;
            end
        end
    end

endmodule

/* rtl/pair_interning_table.sv */
// Top level of the pair interning table: front end, request queue and back end.
//
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+------------------------------------------------
//  i_req    | in        | valid / ready  | req_type, node, left_value, right_value, index
//  o_rsp    | out       | valid / ready  | result_index, out_left, out_right, is_new, status
//
// A read passes through WAIT_HEAD and DECIDE; an insert then walks the chain, through
// WAIT_ENTRY and COMPARE for each entry it compares, and goes to APPEND to store the
// pair or refuse it as full; one registered read of the pair store per entry paces the walk.
// After reset the bucket heads are cleared, one per cycle, all NODES * BUCKETS of them;
// no item is taken meanwhile.
// The front queue holds four items, so requests are taken while the back end works
// or while a finished item waits at the output.
`timescale 1ns / 1ps
module pair_interning_table #(
    parameter int NODES   = 16,
    parameter int ENTRIES = 4096,
    parameter int BUCKETS = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pit_req_if.sink      i_req,
    pit_rsp_if.source    o_rsp
);

    // ENTRIES and BUCKETS must be powers of two (the block does not check); node and slot form the memory address.
    logic          w_job_valid;
    logic          w_job_pop;
    logic          w_clearing;
    pit_pkg::t_job w_job;
    pit_pkg::t_rsp w_rsp;

    pit_front #(
        .NODES(NODES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_req.valid),
        .o_ready       (i_req.ready),
        .i_req_type    (i_req.req_type),
        .i_node        (i_req.node),
        .i_left_value  (i_req.left_value),
        .i_right_value (i_req.right_value),
        .i_entry_index (i_req.entry_index),
        .i_clearing    (w_clearing),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job),
        .i_job_pop     (w_job_pop)
    );

    pit_back #(
        .NODES  (NODES),
        .ENTRIES(ENTRIES),
        .BUCKETS(BUCKETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_clearing  (w_clearing),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp       (w_rsp),
        .i_rsp_ready (o_rsp.ready)
    );

    // The result register sits in the back end and holds while the sink stalls.
    assign o_rsp.result_index = w_rsp.result_index;
    assign o_rsp.out_left     = w_rsp.out_left;
    assign o_rsp.out_right    = w_rsp.out_right;
    assign o_rsp.is_new       = w_rsp.is_new;
    assign o_rsp.status       = w_rsp.status;

endmodule

/* rtl/pit_checker.sv */
// Port checker of the pair interning table and its bind statement.
`timescale 1ns / 1ps
module pit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_result_index,
    input logic [31:0] i_out_left,
    input logic [31:0] i_out_right,
    input logic        i_is_new,
    input logic [1:0]  i_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_index)
        && $stable(i_status) && $stable(i_out_left))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == pit_pkg::ST_FULL |-> !i_is_new && i_result_index == '0
        && i_out_left == '0 && i_out_right == '0)
        else $error("full result carries data");

    a_bad_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == pit_pkg::ST_BAD_READ |-> !i_is_new && i_out_left == '0
        && i_out_right == '0)
        else $error("failed read carries data");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_new |-> i_status == pit_pkg::ST_OK)
        else $error("new entry with error status");

endmodule

bind pair_interning_table pit_checker u_pit_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_result_index (o_rsp.result_index),
    .i_out_left     (o_rsp.out_left),
    .i_out_right    (o_rsp.out_right),
    .i_is_new       (o_rsp.is_new),
    .i_status       (o_rsp.status)
);
